// ===== rtl/alarm_melody_tone_sequencer_macros.svh =====
// assertion helpers shared by the tone sequencer rtl
`ifndef ALARM_MELODY_TONE_SEQUENCER_MACROS_SVH
`define ALARM_MELODY_TONE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define AMTS_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/amts_pkg.sv =====
// ---------------------------------------------------------------------------
// amts_pkg
// Types, constants and melody rom lookups for the alarm tone sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package amts_pkg;

  localparam int TPM_W  = 17;
  localparam int HP_W   = 19;
  localparam int EL_W   = 27;
  localparam int LIM_W  = 27;
  localparam int NOTE_W = 4;
  localparam int MEL_W  = 2;
  localparam int LEN_W  = NOTE_W + 1;

  localparam int MAX_NOTES    = 10;
  localparam int MELODY_COUNT = 4;
  localparam int ROM_SLOTS    = 16;

  localparam int DUR_SHORT_MS = 500;
  localparam int DUR_LONG_MS  = 1000;
  localparam int TPM_RESET    = 80000;

  localparam logic [TPM_W-1:0] TPM_RESET_V  = TPM_W'(TPM_RESET);
  localparam logic [LIM_W-1:0] LIM_SHORT_RV = LIM_W'(TPM_RESET * DUR_SHORT_MS);
  localparam logic [LIM_W-1:0] LIM_LONG_RV  = LIM_W'(TPM_RESET * DUR_LONG_MS);
  localparam logic [HP_W-1:0]  HP_RESET_V   = 19'd305775;

  // register index on the config port
  localparam logic REG_IDX_TPM = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_CHANGE = 2'd3
  } amts_op_t;

  typedef struct packed {
    amts_op_t         opcode;
    logic signed [2:0] step;
  } amts_item_t;

  typedef struct packed {
    logic [LIM_W-1:0] lim_short;
    logic [LIM_W-1:0] lim_long;
  } amts_lim_t;

  function automatic logic [HP_W-1:0] rom_half(input logic [MEL_W-1:0] m,
                                               input logic [NOTE_W-1:0] i);
    logic [HP_W-1:0] hp;
    hp = '0;
    unique case (m)
      2'd0: begin
        case (i)
          4'd0: hp = 19'd305775;
          4'd1: hp = 19'd272423;
          4'd2: hp = 19'd242696;
          default: hp = '0;
        endcase
      end
      2'd1: begin
        case (i)
          4'd0: hp = 19'd200000;
          4'd1: hp = 19'd152890;
          default: hp = '0;
        endcase
      end
      2'd2: begin
        case (i)
          4'd0: hp = 19'd305775;
          4'd1: hp = 19'd242696;
          4'd2: hp = 19'd204081;
          4'd3: hp = 19'd152890;
          4'd4: hp = 19'd204081;
          4'd5: hp = 19'd242696;
          default: hp = '0;
        endcase
      end
      2'd3: begin
        case (i)
          4'd0: hp = 19'd305775;
          4'd1: hp = 19'd242696;
          4'd2: hp = 19'd305775;
          4'd3: hp = 19'd204081;
          4'd4: hp = 19'd305775;
          4'd5: hp = 19'd152890;
          default: hp = '0;
        endcase
      end
    endcase
    return hp;
  endfunction

  // every note of the second melody lasts the long duration, all others short
  function automatic logic rom_long(input logic [MEL_W-1:0] m);
    return (m == 2'd1);
  endfunction

  function automatic logic [LEN_W-1:0] mel_len(input logic [MEL_W-1:0] m);
    logic [LEN_W-1:0] n;
    n = '0;
    unique case (m)
      2'd0: n = LEN_W'(3);
      2'd1: n = LEN_W'(2);
      2'd2: n = LEN_W'(6);
      2'd3: n = LEN_W'(6);
    endcase
    if (n > LEN_W'(MAX_NOTES)) n = LEN_W'(MAX_NOTES);
    if (n > LEN_W'(ROM_SLOTS)) n = LEN_W'(ROM_SLOTS);
    if (n == '0) n = LEN_W'(1);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/amts_cfg.sv =====
// ---------------------------------------------------------------------------
// amts_cfg
// APB register for ticks per ms, with the scaled note duration limits.
// ---------------------------------------------------------------------------
`default_nettype none

module amts_cfg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output amts_pkg::amts_lim_t     lim
);
  import amts_pkg::*;

  logic [TPM_W-1:0] tpm;
  logic             wr_tpm;

  assign pready = 1'b1;
  assign wr_tpm = psel && penable && pwrite && (paddr[2] == REG_IDX_TPM);

  // duration limits are precomputed at write time so the tick path has no multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      tpm           <= TPM_RESET_V;
      lim.lim_short <= LIM_SHORT_RV;
      lim.lim_long  <= LIM_LONG_RV;
    end else if (wr_tpm) begin
      tpm           <= pwdata[TPM_W-1:0];
      lim.lim_short <= LIM_W'(pwdata[TPM_W-1:0] * LIM_W'(DUR_SHORT_MS));
      lim.lim_long  <= LIM_W'(pwdata[TPM_W-1:0] * LIM_W'(DUR_LONG_MS));
    end
  end

  assign prdata = (paddr[2] == REG_IDX_TPM) ? {{(32-TPM_W){1'b0}}, tpm} : '0;

endmodule

`default_nettype wire

// ===== rtl/amts_in_reg.sv =====
// ---------------------------------------------------------------------------
// amts_in_reg
// Input register stage for command and tick items.
// ---------------------------------------------------------------------------
`default_nettype none

module amts_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  amts_pkg::amts_item_t in_item,
  output logic                 item_valid,
  output amts_pkg::amts_item_t item,
  input  logic                 item_ready
);
  import amts_pkg::*;

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/amts_core.sv =====
// ---------------------------------------------------------------------------
// amts_core
// Tone state update per item; the state registers form the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module amts_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  amts_pkg::amts_item_t item,
  output logic                 item_ready,
  input  amts_pkg::amts_lim_t  lim,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 speaker_level,
  output logic                 alarm_active,
  output logic [1:0]           melody_number,
  output logic [3:0]           note_number
);
  import amts_pkg::*;

  logic              level, level_next;
  logic              sounding, sounding_next;
  logic              note_started, note_started_next;
  logic [MEL_W-1:0]  melody, melody_next;
  logic [NOTE_W-1:0] note_index, note_index_next;
  logic [HP_W-1:0]   hp_reload, hp_reload_next;
  logic [HP_W-1:0]   hp_count, hp_count_next;
  logic [EL_W-1:0]   elapsed, elapsed_next;

  logic              take;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  idx_inc;
  logic [NOTE_W-1:0] adv_idx;
  logic [LIM_W-1:0]  limit;
  logic [EL_W-1:0]   el_inc;
  logic signed [3:0] mel_sum;
  logic [MEL_W-1:0]  new_mel;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    len     = mel_len(melody);
    idx_inc = {1'b0, note_index} + LEN_W'(1);
    adv_idx = (idx_inc >= len) ? '0 : idx_inc[NOTE_W-1:0];
    // duration is per melody, so the out-of-range index case needs no remap
    limit   = rom_long(melody) ? lim.lim_long : lim.lim_short;
    el_inc  = (note_started && (elapsed != '1)) ? elapsed + EL_W'(1) : elapsed;

    mel_sum = $signed({2'b00, melody}) + $signed({item.step[2], item.step});
    if (mel_sum >= MELODY_COUNT) begin
      new_mel = '0;
    end else if (mel_sum < 0) begin
      new_mel = MEL_W'(MELODY_COUNT - 1);
    end else begin
      new_mel = mel_sum[MEL_W-1:0];
    end

    level_next        = level;
    sounding_next     = sounding;
    note_started_next = note_started;
    melody_next       = melody;
    note_index_next   = note_index;
    hp_reload_next    = hp_reload;
    hp_count_next     = hp_count;
    elapsed_next      = elapsed;

    unique case (item.opcode)
      OP_TICK: begin
        elapsed_next = el_inc;
        if (hp_count == '0) begin
          hp_count_next = hp_reload;
          if (sounding) begin
            if (!note_started) begin
              note_started_next = 1'b1;
              elapsed_next      = '0;
            end
            level_next = !level;
            if (elapsed_next > limit) begin
              note_index_next   = adv_idx;
              hp_reload_next    = rom_half(melody, adv_idx);
              note_started_next = 1'b0;
            end
          end
        end else begin
          hp_count_next = hp_count - HP_W'(1);
        end
      end
      OP_START: begin
        note_index_next = '0;
        sounding_next   = 1'b1;
      end
      OP_STOP: begin
        sounding_next = 1'b0;
      end
      OP_CHANGE: begin
        melody_next       = new_mel;
        note_started_next = 1'b0;
        note_index_next   = '0;
        hp_reload_next    = rom_half(new_mel, '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      level        <= 1'b0;
      sounding     <= 1'b0;
      note_started <= 1'b0;
      melody       <= '0;
      note_index   <= '0;
      hp_reload    <= HP_RESET_V;
      hp_count     <= '0;
      elapsed      <= '0;
    end else begin
      out_valid <= take || (out_valid && !out_ready);
      if (take) begin
        level        <= level_next;
        sounding     <= sounding_next;
        note_started <= note_started_next;
        melody       <= melody_next;
        note_index   <= note_index_next;
        hp_reload    <= hp_reload_next;
        hp_count     <= hp_count_next;
        elapsed      <= elapsed_next;
      end
    end
  end

  assign speaker_level = level;
  assign alarm_active  = sounding;
  assign melody_number = melody;
  assign note_number   = note_index;

endmodule

`default_nettype wire

// ===== rtl/alarm_melody_tone_sequencer.sv =====
// ---------------------------------------------------------------------------
// alarm_melody_tone_sequencer
// Square-wave buzzer player for four rom melodies, one result per item.
// ---------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   cfg       psel penable pwrite paddr pwdata prdata   apb slave, pready tied high
//   in        in_valid in_ready opcode step             item in
//   out       out_valid out_ready speaker_level         result out
//             alarm_active melody_number note_number
//
// one item per cycle while out_ready is high; an accepted item lands in the input
// register, and the core registers its result together with out_valid.
// the note duration limits are multiplied out when ticks_per_ms is written.
// synchronous reset: melody 0, note 0, alarm off, ticks_per_ms 80000.
// out_ready low holds the result; the input register takes one more item.
`default_nettype none
`include "alarm_melody_tone_sequencer_macros.svh"

module alarm_melody_tone_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic signed [2:0] step,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              speaker_level,
  output logic              alarm_active,
  output logic [1:0]        melody_number,
  output logic [3:0]        note_number
);
  import amts_pkg::*;

  amts_lim_t  lim;
  amts_item_t in_item;
  amts_item_t s1_item;
  logic       s1_valid;
  logic       s1_ready;

  assign in_item.opcode = amts_op_t'(opcode);
  assign in_item.step   = step;

  amts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lim     (lim)
  );

  amts_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (s1_valid),
    .item       (s1_item),
    .item_ready (s1_ready)
  );

  amts_core u_core (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (s1_valid),
    .item          (s1_item),
    .item_ready    (s1_ready),
    .lim           (lim),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .speaker_level (speaker_level),
    .alarm_active  (alarm_active),
    .melody_number (melody_number),
    .note_number   (note_number)
  );

  `AMTS_ASSERT_NOW(a_no_bubble, clk, rst, !out_valid, in_ready, "input stalled with empty output")
  `AMTS_ASSERT_NOW(a_note_range, clk, rst, out_valid, int'(note_number) < MAX_NOTES, "note index out of range")
  `AMTS_ASSERT_NOW(a_mel_range, clk, rst, out_valid, int'(melody_number) < MELODY_COUNT, "melody out of range")
  `AMTS_ASSERT_NEXT(a_stop_quiet, clk, rst, s1_valid && s1_ready && (s1_item.opcode == OP_STOP), !alarm_active, "alarm still active after stop")

endmodule

`default_nettype wire
